### src/pit_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and result codes for the point-in-triangle pipeline.
// No dependencies; every other file imports this package.
package pit_pkg;

  localparam int CoordWidth   = 24;
  localparam int CoordCount   = 12;
  localparam int InDataWidth  = ((CoordCount * CoordWidth + 7) / 8) * 8;
  localparam int OutDataWidth = 8;

  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int CrossWidth = 2 * CoordWidth + 3;
  localparam int CrossLo    = (CrossWidth + 1) / 2;
  localparam int CrossHi    = CrossWidth - CrossLo;
  localparam int DotWidth   = 4 * CoordWidth + 8;
  localparam int DeltaWidth = DotWidth + 2;
  localparam int TermCount  = 15;
  localparam int LimbCount  = 4;
  localparam int LimbWidth  = (DotWidth + LimbCount - 1) / LimbCount;
  localparam int LimbExt    = LimbCount * LimbWidth;
  localparam int PartWidth  = 2 * LimbWidth;
  localparam int WideWidth  = 2 * LimbExt + 2;

  localparam logic [1:0] DecInside = 2'd0;
  localparam logic [1:0] DecSign1  = 2'd1;
  localparam logic [1:0] DecSign2  = 2'd2;
  localparam logic [1:0] DecSum    = 2'd3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic signed [DotWidth-1:0]   dot_t;
  typedef logic signed [DeltaWidth-1:0] delta_t;

  typedef struct packed {
    dot_t dot1;
    dot_t dot2;
    dot_t sa;
    dot_t sb;
    dot_t sc;
  } sums_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] why;
  } verdict_t;

endpackage

### src/pit_front.sv
`timescale 1ns / 1ps
// Edge vectors and cross products: difference, product and subtract stages.
// Depends on pit_pkg.
module pit_front import pit_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  coord_t coord_i [CoordCount],
  output logic   valid_o,
  output cross_t n2q_o [3],
  output cross_t n1q_o [3],
  output cross_t n12_o [3]
);

  logic [2:0] valid_q;
  diff_t      e1_q [3];
  diff_t      e2_q [3];
  diff_t      q_q [3];
  diff_t      lhs [3][3];
  diff_t      rhs [3][3];
  prod_t      pa_q [3][3];
  prod_t      pb_q [3][3];
  cross_t     cr_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lhs[0][k] = e2_q[k];
      rhs[0][k] = q_q[k];
      lhs[1][k] = e1_q[k];
      rhs[1][k] = q_q[k];
      lhs[2][k] = e1_q[k];
      rhs[2][k] = e2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= diff_t'(coord_i[6+k]) - diff_t'(coord_i[3+k]);
        e2_q[k] <= diff_t'(coord_i[9+k]) - diff_t'(coord_i[3+k]);
        q_q[k]  <= diff_t'(coord_i[k])   - diff_t'(coord_i[3+k]);
      end
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          pa_q[c][k] <= lhs[c][(k == 2) ? 0 : k + 1] * rhs[c][(k == 0) ? 2 : k - 1];
          pb_q[c][k] <= lhs[c][(k == 0) ? 2 : k - 1] * rhs[c][(k == 2) ? 0 : k + 1];
          cr_q[c][k] <= cross_t'(pa_q[c][k]) - cross_t'(pb_q[c][k]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n2q_o[k] = cr_q[0][k];
      n1q_o[k] = cr_q[1][k];
      n12_o[k] = cr_q[2][k];
    end
  end

  assign valid_o = valid_q[2];

endmodule

### src/pit_norm.sv
`timescale 1ns / 1ps
// Dot products and squared norms of the cross products, split multiply,
// term assembly and three-term sum stages. Depends on pit_pkg.
module pit_norm import pit_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  cross_t n2q_i [3],
  input  cross_t n1q_i [3],
  input  cross_t n12_i [3],
  output logic   valid_o,
  output sums_t  sums_o
);

  typedef logic signed [2*CrossHi-1:0]      hh_t;
  typedef logic signed [CrossHi+CrossLo:0]  hl_t;
  typedef logic        [2*CrossLo-1:0]      ll_t;

  logic [2:0] valid_q;
  cross_t     opa [TermCount];
  cross_t     opb [TermCount];
  hh_t        hh_q [TermCount];
  hl_t        hl_q [TermCount];
  hl_t        lh_q [TermCount];
  ll_t        ll_q [TermCount];
  dot_t       term_q [TermCount];
  sums_t      sums_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[k]    = n2q_i[k];
      opb[k]    = n12_i[k];
      opa[3+k]  = n1q_i[k];
      opb[3+k]  = n12_i[k];
      opa[6+k]  = n2q_i[k];
      opb[6+k]  = n2q_i[k];
      opa[9+k]  = n1q_i[k];
      opb[9+k]  = n1q_i[k];
      opa[12+k] = n12_i[k];
      opb[12+k] = n12_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < TermCount; t++) begin
        hh_q[t] <= $signed(opa[t][CrossWidth-1:CrossLo]) *
                   $signed(opb[t][CrossWidth-1:CrossLo]);
        hl_q[t] <= $signed(opa[t][CrossWidth-1:CrossLo]) *
                   $signed({1'b0, opb[t][CrossLo-1:0]});
        lh_q[t] <= $signed({1'b0, opa[t][CrossLo-1:0]}) *
                   $signed(opb[t][CrossWidth-1:CrossLo]);
        ll_q[t] <= opa[t][CrossLo-1:0] * opb[t][CrossLo-1:0];
        term_q[t] <= (dot_t'(hh_q[t]) <<< (2 * CrossLo)) +
                     ((dot_t'(hl_q[t]) + dot_t'(lh_q[t])) <<< CrossLo) +
                     dot_t'(ll_q[t]);
      end
      sums_q.dot1 <= term_q[0]  + term_q[1]  + term_q[2];
      sums_q.dot2 <= term_q[3]  + term_q[4]  + term_q[5];
      sums_q.sa   <= term_q[6]  + term_q[7]  + term_q[8];
      sums_q.sb   <= term_q[9]  + term_q[10] + term_q[11];
      sums_q.sc   <= term_q[12] + term_q[13] + term_q[14];
    end
  end

  assign valid_o = valid_q[2];
  assign sums_o  = sums_q;

endmodule

### src/pit_final.sv
`timescale 1ns / 1ps
// Sign tests, sum test d*d > 4*a*b in limb-split multiplies, and the result
// register. Depends on pit_pkg.
module pit_final import pit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sums_t    sums_i,
  output logic     valid_o,
  output verdict_t verdict_o
);

  typedef logic [PartWidth-1:0] part_t;
  typedef logic [WideWidth-1:0] wide_t;
  typedef logic [LimbExt-1:0]   limb_ext_t;

  logic [4:0]    valid_q;
  logic [1:0]    why_q [4];
  logic          pend_q [4];
  logic [DotWidth-1:0] dmag_q, sa_q, sb_q;
  part_t         psq_q [LimbCount][LimbCount];
  part_t         pab_q [LimbCount][LimbCount];
  wide_t         rsq_q [LimbCount];
  wide_t         rab_q [LimbCount];
  wide_t         rsq_d [LimbCount];
  wide_t         rab_d [LimbCount];
  wide_t         tsq_q, tab_q, tsq_d, tab_d;
  verdict_t      verdict_q;
  delta_t        delta;
  logic          rej1, rej2, dpos;
  logic [1:0]    why_d;
  limb_ext_t     dx, ax, bx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_comb begin
    delta = delta_t'($signed(sums_i.sc)) - delta_t'($signed(sums_i.sa)) -
            delta_t'($signed(sums_i.sb));
    rej1  = !sums_i.dot1[DotWidth-1];
    rej2  = sums_i.dot2[DotWidth-1] || (sums_i.dot2 == '0);
    dpos  = !delta[DeltaWidth-1] && (delta != '0);
    priority if (rej1) begin
      why_d = DecSign1;
    end else if (rej2) begin
      why_d = DecSign2;
    end else if (!dpos) begin
      why_d = DecSum;
    end else begin
      why_d = DecInside;
    end
  end

  always_comb begin
    dx = limb_ext_t'(dmag_q);
    ax = limb_ext_t'(sa_q);
    bx = limb_ext_t'(sb_q);
    for (int i = 0; i < LimbCount; i++) begin
      rsq_d[i] = '0;
      rab_d[i] = '0;
      for (int j = 0; j < LimbCount; j++) begin
        rsq_d[i] = rsq_d[i] + (wide_t'(psq_q[i][j]) << (j * LimbWidth));
        rab_d[i] = rab_d[i] + (wide_t'(pab_q[i][j]) << (j * LimbWidth));
      end
    end
    tsq_d = '0;
    tab_d = '0;
    for (int i = 0; i < LimbCount; i++) begin
      tsq_d = tsq_d + (rsq_q[i] << (i * LimbWidth));
      tab_d = tab_d + (rab_q[i] << (i * LimbWidth));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      why_q[0]  <= why_d;
      pend_q[0] <= !rej1 && !rej2 && dpos;
      dmag_q    <= delta[DotWidth-1:0];
      sa_q      <= sums_i.sa;
      sb_q      <= sums_i.sb;
      for (int s = 1; s < 4; s++) begin
        why_q[s]  <= why_q[s-1];
        pend_q[s] <= pend_q[s-1];
      end
      for (int i = 0; i < LimbCount; i++) begin
        for (int j = 0; j < LimbCount; j++) begin
          psq_q[i][j] <= dx[i*LimbWidth +: LimbWidth] * dx[j*LimbWidth +: LimbWidth];
          pab_q[i][j] <= ax[i*LimbWidth +: LimbWidth] * bx[j*LimbWidth +: LimbWidth];
        end
      end
      rsq_q <= rsq_d;
      rab_q <= rab_d;
      tsq_q <= tsq_d;
      tab_q <= tab_d;
      if (pend_q[3] && (tsq_q > (tab_q << 2))) begin
        verdict_q.hit <= 1'b1;
        verdict_q.why <= DecInside;
      end else begin
        verdict_q.hit <= 1'b0;
        verdict_q.why <= pend_q[3] ? DecSum : why_q[3];
      end
    end
  end

  assign valid_o   = valid_q[4];
  assign verdict_o = verdict_q;

endmodule

### src/point_in_triangle_3d.sv
`timescale 1ns / 1ps
// Strict point-in-triangle test in 3D on signed fixed-point coordinates.
// Takes one item per cycle while the pipeline advances.
// The whole pipeline advances when the result register is empty or taken.
// Reset clears every stage valid bit; data registers are not reset.
// Depends on pit_pkg, pit_front, pit_norm and pit_final.
module point_in_triangle_3d import pit_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // query_x,y,z, corner_a_x,y,z, corner_b_x,y,z, corner_c_x,y,z
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // inside_res, decided_by[1:0], zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic     en;
  coord_t   coord [CoordCount];
  logic     front_valid, norm_valid;
  cross_t   n2q [3];
  cross_t   n1q [3];
  cross_t   n12 [3];
  sums_t    sums;
  verdict_t verdict;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int k = 0; k < CoordCount; k++) begin
      coord[k] = s_axis_tdata[k*CoordWidth +: CoordWidth];
    end
  end

  pit_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .coord_i (coord),
    .valid_o (front_valid),
    .n2q_o   (n2q),
    .n1q_o   (n1q),
    .n12_o   (n12)
  );

  pit_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .n2q_i   (n2q),
    .n1q_i   (n1q),
    .n12_i   (n12),
    .valid_o (norm_valid),
    .sums_o  (sums)
  );

  pit_final u_final (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (norm_valid),
    .sums_i    (sums),
    .valid_o   (m_axis_tvalid),
    .verdict_o (verdict)
  );

  assign m_axis_tdata = OutDataWidth'({verdict.why, verdict.hit});

endmodule

### src/pit_check.sv
`timescale 1ns / 1ps
// Port-level checks for point_in_triangle_3d and the bind that attaches them.
// Depends on pit_pkg.
module pit_check import pit_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [InDataWidth-1:0]  s_axis_tdata,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [OutDataWidth-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == DecInside)))
    else $error("inside flag and decision code disagree");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataWidth-1:3] == '0))
    else $error("nonzero fill bits in result");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_free_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off with empty result register");

endmodule

bind point_in_triangle_3d pit_check u_check (.*);
